@@ design/ted_pkg.sv @@
package ted_pkg;

  localparam int CMD_W    = 2;
  localparam int VOL_W    = 16;
  localparam int SENS_W   = 4;
  localparam int WIN_W    = 24;
  localparam int HOLD_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int REASON_W = 3;

  localparam logic [SENS_W-1:0] SENS_RST = 4'd5;
  localparam logic [WIN_W-1:0]  WIN_RST  = 24'd800000;
  localparam logic [HOLD_W-1:0] HOLD_RST = 32'd3000000;

  // loud threshold integer part and silence threshold base, both 8.8
  localparam logic [6:0]  LOUD_BASE  = 7'd90;
  localparam logic [11:0] QUIET_BASE = 12'd768;

  typedef enum logic [CMD_W-1:0] {
    CMD_LEVEL = 2'd0,
    CMD_PRESS = 2'd1,
    CMD_FORCE = 2'd2,
    CMD_ARM   = 2'd3
  } cmd_t;

  typedef enum logic [REASON_W-1:0] {
    WHY_NONE    = 3'd0,
    WHY_LOUD    = 3'd1,
    WHY_SILENCE = 3'd2,
    WHY_TRIPLE  = 3'd3,
    WHY_FORCED  = 3'd4
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS   = 2'd0,
    REG_WINDOW = 2'd1,
    REG_HOLD   = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic loud_hit;
    logic silence_hit;
    logic in_silence_nxt;
    logic start_load;
  } level_res_t;

  typedef struct packed {
    logic push;
    logic clear;
  } press_ctl_t;

endpackage

@@ design/tamper_event_detector_top.sv @@
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   in_cmd, in_now_us, in_volume
// out_     output     out_valid / out_stall out_triggered, out_newly_triggered,
//                                           out_trigger_reason
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle while out_stall is low; an accepted item sits in the input
// register and its result is loaded into the output register when it moves on.
// all state (alarm, silence, press history) updates together with that load.
// synchronous active-low reset; sensitivity, window and hold return to defaults.
// out_stall holds the output register and backs up into in_stall only when the
// input register is also full.
module tamper_event_detector_top #(
  parameter int PRESS_HISTORY = 3,
  parameter int TIME_BITS     = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ted_pkg::CMD_W-1:0]      in_cmd,
  input  logic [TIME_BITS-1:0]           in_now_us,
  input  logic [ted_pkg::VOL_W-1:0]      in_volume,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_triggered,
  output logic                           out_newly_triggered,
  output logic [ted_pkg::REASON_W-1:0]   out_trigger_reason,
  input  logic                           cfg_we,
  input  logic [ted_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ted_pkg::CFG_W-1:0]      cfg_wdata
);
  import ted_pkg::*;

  logic [SENS_W-1:0]    sens_r;
  logic [WIN_W-1:0]     window_r;
  logic [HOLD_W-1:0]    hold_r;

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  cmd_t                 s1_cmd_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic [VOL_W-1:0]     s1_vol_r;

  logic                 armed_r, armed_nxt;
  logic                 latched_r, latched_nxt;
  logic                 silence_r, silence_nxt;
  logic [TIME_BITS-1:0] start_r;
  logic                 start_load;

  logic                 out_valid_r, out_valid_nxt;
  logic                 trig_r;
  reason_t              why_r, why_nxt;

  logic                 out_ready;
  logic                 go;
  logic                 in_take;
  logic                 active;
  level_res_t           lvl;
  press_ctl_t           pctl;
  logic                 triple;

  assign out_ready = !out_valid_r || !out_stall;
  assign go        = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;
  assign active    = armed_r && !latched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r   <= SENS_RST;
      window_r <= WIN_RST;
      hold_r   <= HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SENS:   sens_r   <= cfg_wdata[SENS_W-1:0];
        REG_WINDOW: window_r <= cfg_wdata[WIN_W-1:0];
        REG_HOLD:   hold_r   <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  ted_level #(
    .TIME_BITS(TIME_BITS)
  ) u_level (
    .now          (s1_now_r),
    .volume       (s1_vol_r),
    .sens         (sens_r),
    .hold         (hold_r),
    .in_silence   (silence_r),
    .silence_start(start_r),
    .res          (lvl)
  );

  assign pctl.push  = go && active && (s1_cmd_r == CMD_PRESS);
  assign pctl.clear = go && (s1_cmd_r == CMD_ARM);

  ted_press #(
    .PRESS_HISTORY(PRESS_HISTORY),
    .TIME_BITS    (TIME_BITS)
  ) u_press (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .now   (s1_now_r),
    .window(window_r),
    .triple(triple)
  );

  always_comb begin
    armed_nxt   = armed_r;
    latched_nxt = latched_r;
    silence_nxt = silence_r;
    start_load  = 1'b0;
    why_nxt     = WHY_NONE;
    case (s1_cmd_r)
      CMD_ARM: begin
        armed_nxt   = 1'b1;
        latched_nxt = 1'b0;
        silence_nxt = 1'b0;
      end
      CMD_FORCE: begin
        if (!latched_r) begin
          latched_nxt = 1'b1;
          why_nxt     = WHY_FORCED;
        end
      end
      CMD_LEVEL: begin
        if (active) begin
          silence_nxt = lvl.in_silence_nxt;
          start_load  = lvl.start_load;
          if (lvl.loud_hit) begin
            latched_nxt = 1'b1;
            why_nxt     = WHY_LOUD;
          end else if (lvl.silence_hit) begin
            latched_nxt = 1'b1;
            why_nxt     = WHY_SILENCE;
          end
        end
      end
      CMD_PRESS: begin
        if (active && triple) begin
          latched_nxt = 1'b1;
          why_nxt     = WHY_TRIPLE;
        end
      end
      default: ;
    endcase
  end

  assign s1_valid_nxt  = in_take ? 1'b1 : (go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = go ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      armed_r     <= 1'b0;
      latched_r   <= 1'b0;
      silence_r   <= 1'b0;
      start_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (go) begin
        armed_r   <= armed_nxt;
        latched_r <= latched_nxt;
        silence_r <= silence_nxt;
        if (start_load) begin
          start_r <= s1_now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= cmd_t'(in_cmd);
      s1_now_r <= in_now_us;
      s1_vol_r <= in_volume;
    end
    if (go) begin
      trig_r <= latched_nxt;
      why_r  <= why_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_triggered       = trig_r;
  assign out_newly_triggered = (why_r != WHY_NONE);
  assign out_trigger_reason  = why_r;

endmodule

@@ design/ted_level.sv @@
module ted_level #(
  parameter int TIME_BITS = 48
) (
  input  logic [TIME_BITS-1:0]        now,
  input  logic [ted_pkg::VOL_W-1:0]   volume,
  input  logic [ted_pkg::SENS_W-1:0]  sens,
  input  logic [ted_pkg::HOLD_W-1:0]  hold,
  input  logic                        in_silence,
  input  logic [TIME_BITS-1:0]        silence_start,
  output ted_pkg::level_res_t         res
);
  import ted_pkg::*;

  logic [6:0]           loud_int;
  logic [VOL_W-1:0]     loud_thr;
  logic [VOL_W-1:0]     quiet_thr;
  logic [TIME_BITS-1:0] hold_ext;
  logic                 held_long;

  // 90 - 2*sens never goes negative for a 4-bit sensitivity
  assign loud_int  = LOUD_BASE - {2'b00, sens, 1'b0};
  assign loud_thr  = {1'b0, loud_int, 8'h00};
  assign quiet_thr = {4'h0, QUIET_BASE + {1'b0, sens, 7'h00}};
  assign hold_ext  = {{(TIME_BITS-HOLD_W){1'b0}}, hold};

  // elapsed time saturates at zero when time runs backwards
  assign held_long = (now >= silence_start) && ((now - silence_start) > hold_ext);

  always_comb begin
    res = '0;
    res.in_silence_nxt = in_silence;
    if (volume > loud_thr) begin
      res.loud_hit       = 1'b1;
      res.in_silence_nxt = 1'b0;
    end else if (volume < quiet_thr) begin
      if (!in_silence) begin
        res.in_silence_nxt = 1'b1;
        res.start_load     = 1'b1;
      end else begin
        res.silence_hit = held_long;
      end
    end else begin
      res.in_silence_nxt = 1'b0;
    end
  end

endmodule

@@ design/ted_press.sv @@
module ted_press #(
  parameter int PRESS_HISTORY = 3,
  parameter int TIME_BITS     = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ted_pkg::press_ctl_t        ctl,
  input  logic [TIME_BITS-1:0]       now,
  input  logic [ted_pkg::WIN_W-1:0]  window,
  output logic                       triple
);
  import ted_pkg::*;

  localparam int FW = $clog2(PRESS_HISTORY + 1);
  localparam logic [FW-1:0] FULL = FW'(PRESS_HISTORY);

  logic [TIME_BITS-1:0] stamps_r   [PRESS_HISTORY];
  logic [TIME_BITS-1:0] stamps_nxt [PRESS_HISTORY];
  logic [TIME_BITS-1:0] st_a       [PRESS_HISTORY];
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        fill_nxt;
  logic [FW-1:0]        fill_a;
  logic [FW-1:0]        fill_b;
  logic [FW-1:0]        kept;
  logic [TIME_BITS-1:0] win_ext;

  function automatic logic span_gt(input logic [TIME_BITS-1:0] later,
                                   input logic [TIME_BITS-1:0] earlier,
                                   input logic [TIME_BITS-1:0] lim);
    return (later >= earlier) && ((later - earlier) > lim);
  endfunction

  assign win_ext = {{(TIME_BITS-WIN_W){1'b0}}, window};

  // append the new stamp, shifting out the oldest when full
  always_comb begin
    if (fill_r < FULL) begin
      for (int i = 0; i < PRESS_HISTORY; i++) begin
        st_a[i] = (FW'(i) == fill_r) ? now : stamps_r[i];
      end
      fill_a = fill_r + 1'b1;
    end else begin
      for (int i = 0; i < PRESS_HISTORY - 1; i++) begin
        st_a[i] = stamps_r[i + 1];
      end
      st_a[PRESS_HISTORY-1] = now;
      fill_a = FULL;
    end
  end

  assign triple = (fill_a == FULL) &&
                  !span_gt(st_a[PRESS_HISTORY-1], st_a[0], win_ext);
  assign fill_b = triple ? '0 : fill_a;

  // drop stamps that fell out of the window, keeping order
  always_comb begin
    stamps_nxt = st_a;
    fill_nxt   = fill_b;
    kept       = '0;
    if ((fill_b != '0) && span_gt(now, st_a[0], win_ext)) begin
      for (int i = 0; i < PRESS_HISTORY; i++) begin
        if ((FW'(i) < fill_b) && !span_gt(now, st_a[i], win_ext)) begin
          for (int k = 0; k < PRESS_HISTORY; k++) begin
            if (FW'(k) == kept) begin
              stamps_nxt[k] = st_a[i];
            end
          end
          kept = kept + 1'b1;
        end
      end
      fill_nxt = kept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.clear) begin
      fill_r <= '0;
    end else if (ctl.push) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      stamps_r <= stamps_nxt;
    end
  end

endmodule
